[hw/rtl/assert_macros.svh]
// assert_macros.svh: assertion shorthands for the uidq RTL.
// Included by files that carry concurrent assertions; needs clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, suspended while rst is high.
`define UIDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clk edge, including during reset.
`define UIDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/uidq_pkg.sv]
// uidq_pkg: shared types and constants of the unique-id FIFO queue.
// No dependencies; used by the cell and the top level.
package uidq_pkg;

  localparam int UIDQ_DEPTH = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_SERVE  = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_FOUND     = 3'd4,
    STAT_NOT_FOUND = 3'd5
  } status_t;

  // Search token that walks the chain, one cell per cycle
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [31:0] tag;
  } tok_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic shift;  // serve: every cell takes its right neighbor's entry
    logic load;   // add commit: the cell at slot == count takes the new entry
  } cell_ctl_t;

endpackage

[hw/rtl/uidq_ifs.sv]
// uidq_ifs: valid/ready channel interfaces for commands and results.
// Depends on nothing; the payload fields follow the queue's item formats.
interface uidq_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] ticket_id;
  logic [31:0]        ticket_tag;

  modport source(output valid, command, ticket_id, ticket_tag, input ready);
  modport sink(input valid, command, ticket_id, ticket_tag, output ready);
endinterface

interface uidq_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] result_id;
  logic [31:0]        result_tag;
  logic [4:0]         occupancy;

  modport source(output valid, status, result_id, result_tag, occupancy, input ready);
  modport sink(input valid, status, result_id, result_tag, occupancy, output ready);
endinterface

[hw/rtl/uidq_cell.sv]
// uidq_cell: one queue slot plus one stage of the search token path.
// Depends on uidq_pkg (tok_t, cell_ctl_t).
module uidq_cell
  import uidq_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctl_t          ctl,
  input  logic [CNT_W-1:0]   count,
  input  logic signed [31:0] qid,
  input  logic [31:0]        qtag,
  input  logic signed [31:0] nbr_id,
  input  logic [31:0]        nbr_tag,
  input  tok_t               tok_in,
  output tok_t               tok_out,
  output logic signed [31:0] id,
  output logic [31:0]        tag
);

  logic        live;
  logic        hit_here;
  logic        tok_vld;
  logic        tok_hit;
  logic [31:0] tok_tag;

  // Slot holds a queued entry when it lies below the fill count
  assign live     = count > CNT_W'(INDEX);
  assign hit_here = tok_in.valid && live && (id == qid);

  // Entry storage: shift toward the head on serve, load at the tail on add
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      id  <= nbr_id;
      tag <= nbr_tag;
    end else if (ctl.load && (count == CNT_W'(INDEX))) begin
      id  <= qid;
      tag <= qtag;
    end
  end

  // Token stage: valid is control, hit and tag are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_vld <= 1'b0;
    end else begin
      tok_vld <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_hit <= tok_in.hit | hit_here;
    tok_tag <= tok_in.hit ? tok_in.tag : tag;
  end

  assign tok_out = '{valid: tok_vld, hit: tok_hit, tag: tok_tag};

endmodule

[hw/rtl/unique_id_fifo_queue.sv]
// unique_id_fifo_queue: top level, command sequencer, cell chain and result register.
// Depends on uidq_pkg, uidq_ifs (uidq_cmd_if, uidq_res_if), uidq_cell, assert_macros.svh.
`include "assert_macros.svh"

// FIFO queue of (id, tag) entries that refuses duplicate ids. Entries sit in a
// row of QUEUE_DEPTH cells, oldest in cell 0; a serve shifts every cell one
// place toward the head. Serve and peek read cell 0 and load the result
// register at the edge that accepts the command, so the result is offered in the
// cycle after acceptance. Add and search send a token down the cell row, one
// cell per cycle, collecting the id match. The token passes the inject register
// and the token stage of every cell; the sequencer then latches the outcome in
// the pending registers and moves it to the result register once that is free,
// so a longer cell row or a stalled response delays the result. One command is
// in work at a time; a new command is accepted when the sequencer is idle and
// the result register is empty or being read. No clearing pass after reset.
module unique_id_fifo_queue
  import uidq_pkg::*;
#(
  parameter int QUEUE_DEPTH = UIDQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  uidq_cmd_if.sink   request,
  uidq_res_if.source response
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               inject;
  logic               qadd;
  logic signed [31:0] qid;
  logic [31:0]        qtag;
  status_t            pend_status;
  logic signed [31:0] pend_id;
  logic [31:0]        pend_tag;
  logic               out_valid;
  status_t            out_status;
  logic signed [31:0] out_id;
  logic [31:0]        out_tag;
  logic [4:0]         out_occ;
  logic               out_load;
  logic               accept;
  logic               is_scan_cmd;
  logic               full;
  logic               out_free;
  logic [31:0]        cnt_ext;
  logic [31:0]        cnt_next_ext;
  cell_ctl_t          ctl;
  tok_t               chain [QUEUE_DEPTH+1];
  logic signed [31:0] cell_id [QUEUE_DEPTH];
  logic [31:0]        cell_tag [QUEUE_DEPTH];

  // Handshake
  assign out_free       = !out_valid || response.ready;
  assign request.ready  = (state == ST_IDLE) && out_free;
  assign accept         = request.valid && request.ready;
  assign is_scan_cmd    = (request.command == CMD_ADD) || (request.command == CMD_SEARCH);
  assign full           = count == CNT_W'(QUEUE_DEPTH);

  // Result register takes a new item on a serve or peek, or when a scan result is sent
  assign out_load = (accept && !is_scan_cmd) || ((state == ST_RESP) && out_free);

  // Cell controls
  assign ctl.shift = accept && (request.command == CMD_SERVE) && (count != '0);
  assign ctl.load  = (state == ST_SCAN) && chain[QUEUE_DEPTH].valid && qadd &&
                     !chain[QUEUE_DEPTH].hit && !full;

  always_comb begin
    count_next = count;
    if (ctl.shift) begin
      count_next = count - CNT_W'(1);
    end else if (ctl.load) begin
      count_next = count + CNT_W'(1);
    end
  end

  // Occupancy is the count cut to the result field's five bits
  assign cnt_ext      = 32'(count);
  assign cnt_next_ext = 32'(count_next);

  // Token enters cell 0 in the cycle after an add or search is accepted
  assign chain[0] = '{valid: inject, hit: 1'b0, tag: 32'd0};

  // Cell row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [31:0] nbr_id;
    logic [31:0]        nbr_tag;

    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nbr_id  = cell_id[i+1];
      assign nbr_tag = cell_tag[i+1];
    end else begin : g_last
      assign nbr_id  = cell_id[i];
      assign nbr_tag = cell_tag[i];
    end

    uidq_cell #(
      .INDEX(i),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .count   (count),
      .qid     (qid),
      .qtag    (qtag),
      .nbr_id  (nbr_id),
      .nbr_tag (nbr_tag),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1]),
      .id      (cell_id[i]),
      .tag     (cell_tag[i])
    );
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      inject    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count  <= count_next;
      inject <= accept && is_scan_cmd;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_scan_cmd) begin
              qid    <= request.ticket_id;
              qtag   <= request.ticket_tag;
              qadd   <= request.command == CMD_ADD;
              state  <= ST_SCAN;
            end else begin
              out_occ   <= cnt_next_ext[4:0];
              if (count == '0) begin
                out_status <= STAT_EMPTY;
                out_id     <= '0;
                out_tag    <= '0;
              end else begin
                out_status <= STAT_DONE;
                out_id     <= cell_id[0];
                out_tag    <= cell_tag[0];
              end
            end
          end
        end
        ST_SCAN: begin
          if (chain[QUEUE_DEPTH].valid) begin
            state <= ST_RESP;
            if (qadd) begin
              pend_id  <= '0;
              pend_tag <= '0;
              if (chain[QUEUE_DEPTH].hit) begin
                pend_status <= STAT_DUPLICATE;
              end else if (full) begin
                pend_status <= STAT_FULL;
              end else begin
                pend_status <= STAT_DONE;
              end
            end else if (chain[QUEUE_DEPTH].hit) begin
              pend_status <= STAT_FOUND;
              pend_id     <= qid;
              pend_tag    <= chain[QUEUE_DEPTH].tag;
            end else begin
              pend_status <= STAT_NOT_FOUND;
              pend_id     <= '0;
              pend_tag    <= '0;
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_status <= pend_status;
            out_id     <= pend_id;
            out_tag    <= pend_tag;
            out_occ    <= cnt_ext[4:0];
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign response.valid      = out_valid;
  assign response.status     = out_status;
  assign response.result_id  = out_id;
  assign response.result_tag = out_tag;
  assign response.occupancy  = out_occ;

  // Checks
  `UIDQ_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `UIDQ_ASSERT(a_tok_in_scan, chain[QUEUE_DEPTH].valid |-> state == ST_SCAN, "token outside scan")
  `UIDQ_ASSERT(a_serve_dec, ctl.shift |=> count == $past(count) - CNT_W'(1), "serve miscount")
  `UIDQ_ASSERT(a_add_inc, ctl.load |=> count == $past(count) + CNT_W'(1), "add miscount")
  `UIDQ_ASSERT(a_no_both, !(ctl.shift && ctl.load), "shift and load together")

endmodule
